// ===== sv/masr_pkg.sv =====
// Shared constants, types and lookup functions for the motor assist request scheduler.
package masr_pkg;

    // Flag bits of the command flags byte.
    localparam logic [7:0] FLAG_LIGHT = 8'h80;
    localparam logic [7:0] FLAG_WALK  = 8'h20;
    localparam logic [7:0] FLAG_OVER  = 8'h01;

    // Reset value of the gear count register.
    localparam logic [7:0] GEAR_COUNT_RESET = 8'd5;

    // Number of supported level counts and duty table row length.
    localparam int NUM_LEVELS = 5;
    localparam int ROW_LEN    = 11;

    typedef logic [2:0] level_sel_t;
    typedef logic [3:0] duty_idx_t;
    typedef logic [7:0] duty_row_t [ROW_LEN];

    // Command contents derived from one transaction.
    typedef struct packed {
        logic [7:0] assist;
        logic [7:0] flags;
    } cmd_t;

    // Supported level counts, in ascending order.
    localparam logic [3:0] LEVEL_OPTS [NUM_LEVELS] = '{4'd1, 4'd3, 4'd5, 4'd6, 4'd9};

    // Duty bytes per level count; the entry after the top gear is walk assist.
    localparam duty_row_t DUTY_TAB [NUM_LEVELS] = '{
        '{8'h00, 8'h66, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h66, 8'h8C, 8'hB3, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h66, 8'h8C, 8'hB3, 8'hD9, 8'hFF, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h66, 8'h84, 8'hA2, 8'hC0, 8'hDE, 8'hFF, 8'h32, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h66, 8'h79, 8'h89, 8'h9C, 8'hAF, 8'hC2, 8'hD5, 8'hE8, 8'hFF, 8'h32}
    };

    // Snap a configured gear count to the nearest supported count; ties go up.
    function automatic level_sel_t snap_level(input logic [7:0] count);
        level_sel_t sel;
        if (count <= 8'd1) begin
            sel = 3'd0;
        end else if (count <= 8'd3) begin
            sel = 3'd1;
        end else if (count <= 8'd5) begin
            sel = 3'd2;
        end else if (count <= 8'd7) begin
            sel = 3'd3;
        end else begin
            sel = 3'd4;
        end
        return sel;
    endfunction

    // Look up one duty byte; codes outside the table read as zero.
    function automatic logic [7:0] duty_lookup(input level_sel_t sel, input duty_idx_t idx);
        logic [7:0] val;
        val = 8'h00;
        if ((sel < 3'(NUM_LEVELS)) && (idx < 4'(ROW_LEN))) begin
            val = DUTY_TAB[sel][idx];
        end
        return val;
    endfunction

endpackage

// ===== sv/masr_calc.sv =====
// Combinational assist byte and flags byte computation for one transaction.
module masr_calc (
    input  masr_pkg::level_sel_t level_sel,
    input  logic [7:0]           active_gear,
    input  logic                 headlight_on,
    input  logic                 walk_active,
    input  logic [15:0]          road_speed,
    input  logic [15:0]          speed_cap,
    output masr_pkg::cmd_t       cmd
);

    logic [3:0]          max_gear;
    masr_pkg::duty_idx_t idx;
    logic                over;

    // Clamp the gear to 1..max, or pick the walk entry.
    always_comb
    begin
        max_gear = masr_pkg::LEVEL_OPTS[level_sel];
        if (walk_active) begin
            idx = max_gear + 4'd1;
        end else if (active_gear == 8'd0) begin
            idx = 4'd1;
        end else if (active_gear > {4'd0, max_gear}) begin
            idx = max_gear;
        end else begin
            idx = active_gear[3:0];
        end
    end

    // Over-speed only counts when a cap is set.
    assign over = (speed_cap != 16'd0) && (road_speed > speed_cap);

    // Assemble the command contents.
    always_comb
    begin
        cmd.assist = masr_pkg::duty_lookup(level_sel, idx);
        cmd.flags  = (headlight_on ? masr_pkg::FLAG_LIGHT : 8'h00)
                   | (walk_active  ? masr_pkg::FLAG_WALK  : 8'h00)
                   | (over         ? masr_pkg::FLAG_OVER  : 8'h00);
    end

endmodule

// ===== sv/motor_assist_request_scheduler.sv =====
// Top level of the motor assist request scheduler.
//
// Input channel (in_valid/in_ready) carries one transaction per item: func 0
// is a request check that may mark a command pending, func 1 is a send tick
// that emits the pending command. Every transaction yields exactly one result
// on the output channel (out_valid/out_ready); send_valid tells whether the
// result carries a command, otherwise all command fields are zero.
// The gear count register is written through cfg_we/cfg_data and is snapped
// to a supported level count as it is written.
// Each accepted transaction passes through the input register into the result
// register. Throughput: one transaction per cycle while the receiver does not
// stall, set by the compare and table lookup logic between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills next, and in_ready drops only when both are occupied.
// Reset clears both pipeline valid bits, the pending marks and the last-sent
// record, and loads a gear count of five.
module motor_assist_request_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic        force_req,
    input  logic [7:0]  active_gear,
    input  logic        headlight_on,
    input  logic        walk_active,
    input  logic [15:0] road_speed,
    input  logic [15:0] speed_cap,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_valid,
    output logic [7:0]  assist_code,
    output logic        light_bit,
    output logic        walk_bit,
    output logic        over_speed_bit
);

    masr_pkg::level_sel_t level_sel_reg;

    // Input register.
    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic        s1_force_reg;
    logic [7:0]  s1_gear_reg;
    logic        s1_light_reg;
    logic        s1_walk_reg;
    logic [15:0] s1_speed_reg;
    logic [15:0] s1_cap_reg;

    // Scheduler state.
    logic       send_pending_reg;
    logic       force_pending_reg;
    logic [7:0] last_assist_reg;
    logic [7:0] last_flags_reg;

    // Result register.
    logic       out_valid_reg;
    logic       send_valid_reg;
    logic [7:0] assist_code_reg;
    logic       light_bit_reg;
    logic       walk_bit_reg;
    logic       over_bit_reg;

    masr_pkg::cmd_t cmd;
    logic           advance;
    logic           in_accept;
    logic           changed;
    logic           do_send;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    // Gear count register, stored as its snapped level selection.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_sel_reg <= masr_pkg::snap_level(masr_pkg::GEAR_COUNT_RESET);
        end else if (cfg_we) begin
            level_sel_reg <= masr_pkg::snap_level(cfg_data);
        end
    end

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_func_reg  <= func;
            s1_force_reg <= force_req;
            s1_gear_reg  <= active_gear;
            s1_light_reg <= headlight_on;
            s1_walk_reg  <= walk_active;
            s1_speed_reg <= road_speed;
            s1_cap_reg   <= speed_cap;
        end
    end

    masr_calc u_calc (
        .level_sel    (level_sel_reg),
        .active_gear  (s1_gear_reg),
        .headlight_on (s1_light_reg),
        .walk_active  (s1_walk_reg),
        .road_speed   (s1_speed_reg),
        .speed_cap    (s1_cap_reg),
        .cmd          (cmd)
    );

    assign changed = (cmd.assist != last_assist_reg) || (cmd.flags != last_flags_reg);
    assign do_send = s1_func_reg && (send_pending_reg || force_pending_reg);

    // Pending marks and the record of the last command sent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            send_pending_reg  <= 1'b0;
            force_pending_reg <= 1'b0;
            last_assist_reg   <= 8'h00;
            last_flags_reg    <= 8'h00;
        end else if (advance) begin
            if (!s1_func_reg) begin
                if (s1_force_reg || changed) begin
                    send_pending_reg <= 1'b1;
                end
                if (s1_force_reg) begin
                    force_pending_reg <= 1'b1;
                end
            end else if (do_send) begin
                send_pending_reg  <= 1'b0;
                force_pending_reg <= 1'b0;
                last_assist_reg   <= cmd.assist;
                last_flags_reg    <= cmd.flags;
            end
        end
    end

    // Result register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload; fields are zero when no command is sent.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            send_valid_reg  <= do_send;
            assist_code_reg <= do_send ? cmd.assist : 8'h00;
            light_bit_reg   <= do_send && s1_light_reg;
            walk_bit_reg    <= do_send && ((cmd.flags & masr_pkg::FLAG_WALK) != 8'h00);
            over_bit_reg    <= do_send && ((cmd.flags & masr_pkg::FLAG_OVER) != 8'h00);
        end
    end

    assign out_valid      = out_valid_reg;
    assign send_valid     = send_valid_reg;
    assign assist_code    = assist_code_reg;
    assign light_bit      = light_bit_reg;
    assign walk_bit       = walk_bit_reg;
    assign over_speed_bit = over_bit_reg;

    // A forced request always leaves a send pending as well.
    a_force_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
        force_pending_reg |-> send_pending_reg)
        else $error("force pending without send pending");

    // A tick that sends clears both pending marks.
    a_send_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && do_send) |=> (!send_pending_reg && !force_pending_reg))
        else $error("pending marks survived a send");

    // A result without a command carries all-zero fields.
    a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_valid) |->
            (assist_code == 8'h00 && !light_bit && !walk_bit && !over_speed_bit))
        else $error("non-send result carries command fields");

    // Input backpressure only when both pipeline registers are full and stalled.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule
